[design/bmm_pkg.sv]
// Shared constants, codes and request type for the banked ROM/RAM mapper.
`default_nettype none

package bmm_pkg;

    localparam int ROM_BYTES_C = 131072;
    localparam int RAM_BYTES_C = 32768;

    localparam int BUS_AW       = 13;
    localparam int ROM_PAGE_W   = 7;
    localparam int ROM_OFFSET_W = 10;
    localparam int RAM_PAGE_W   = 6;
    localparam int RAM_OFFSET_W = 9;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    localparam logic [BUS_AW-1:0] LOCK_ADDR_A  = 13'h1FFC;
    localparam logic [BUS_AW-1:0] LOCK_ADDR_B  = 13'h1FFD;
    localparam logic [BUS_AW-1:0] UNLOCK_LO    = 13'h1000;
    localparam logic [BUS_AW-1:0] UNLOCK_HI    = 13'h1BFF;
    localparam logic [BUS_AW-1:0] BANK_REG_LO  = 13'h003C;
    localparam logic [BUS_AW-1:0] BANK_REG_HI  = 13'h003F;
    localparam logic [7:0]        LOCKED_BLOCK = 8'hFF;
    localparam logic [1:0]        SLOT_LAST    = 2'd3;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_RAM  = 2'd1,
        SRC_ROM  = 2'd2
    } src_t;

    typedef struct packed {
        logic ram_we;
        logic ram_re;
        logic rom_we;
        logic rom_re;
        src_t src;
    } bmm_req_t;

endpackage

`default_nettype wire

[design/bmm_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/bmm_decode.sv]
// Slot block registers, slot 3 lock and access decode for the mapper.
`default_nettype none

module bmm_decode
    import bmm_pkg::*;
#(
    parameter int ROM_BYTES = ROM_BYTES_C,
    parameter int RAM_BYTES = RAM_BYTES_C
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [1:0]                   mode,
    input  wire logic [15:0]                  address,
    input  wire logic [7:0]                   data,
    input  wire logic [16:0]                  load_offset,
    output bmm_req_t                          req,
    output logic      [$clog2(RAM_BYTES)-1:0] ram_addr,
    output logic      [7:0]                   ram_wdata,
    output logic      [$clog2(ROM_BYTES)-1:0] rom_addr
);

    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int ROM_AW = $clog2(ROM_BYTES);

    logic [7:0]        slot_block_reg [4];
    logic [7:0]        slot_block_next [4];
    logic              lock_reg;
    logic              lock_next;
    logic [BUS_AW-1:0] a;
    logic [1:0]        slot;
    logic [7:0]        blk;
    logic              is_bus;
    logic              is_bank;
    logic [ROM_PAGE_W+ROM_OFFSET_W-1:0] rom_idx;
    logic [RAM_PAGE_W+RAM_OFFSET_W-1:0] ram_idx;

    assign a      = address[BUS_AW-1:0];
    assign slot   = a[11:10];
    assign is_bus = (mode == MODE_READ) || (mode == MODE_WRITE);

    always_comb
    begin
        lock_next = lock_reg;
        if ((a == LOCK_ADDR_A) || (a == LOCK_ADDR_B))
        begin
            lock_next = 1'b1;
        end
        else if (lock_reg && (a inside {[UNLOCK_LO:UNLOCK_HI]}))
        begin
            lock_next = 1'b0;
        end
    end

    assign is_bank = a inside {[BANK_REG_LO:BANK_REG_HI]};
    assign blk     = (lock_next && (slot == SLOT_LAST)) ? LOCKED_BLOCK : slot_block_reg[slot];
    assign rom_idx = {blk[ROM_PAGE_W-1:0], a[ROM_OFFSET_W-1:0]};
    assign ram_idx = {blk[RAM_PAGE_W-1:0], a[RAM_OFFSET_W-1:0]};

    always_comb
    begin
        req        = '0;
        req.src    = SRC_ZERO;
        case (mode)
            MODE_READ:
            begin
                if (a[12])
                begin
                    if (blk[7])
                    begin
                        req.rom_re = 1'b1;
                        req.src    = SRC_ROM;
                    end
                    else if (a[9])
                    begin
                        req.ram_re = 1'b1;
                        req.src    = SRC_RAM;
                    end
                    else
                    begin
                        req.ram_we = 1'b1;
                    end
                end
            end
            MODE_WRITE:
            begin
                req.ram_we = !is_bank && a[12] && !blk[7] && !a[9];
            end
            MODE_LOAD:
            begin
                req.rom_we = 1'b1;
            end
            default:
            begin
                req.src = SRC_ZERO;
            end
        endcase
    end

    assign ram_wdata = (mode == MODE_WRITE) ? data : 8'h00;
    assign ram_addr  = ram_idx[RAM_AW-1:0];
    assign rom_addr  = (mode == MODE_LOAD) ? load_offset[ROM_AW-1:0] : rom_idx[ROM_AW-1:0];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            slot_block_next[i] = slot_block_reg[i];
        end
        if (accept && (mode == MODE_WRITE) && is_bank)
        begin
            slot_block_next[a[1:0]] = data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                slot_block_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (accept && is_bus)
            begin
                lock_reg <= lock_next;
            end
            for (int i = 0; i < 4; i++)
            begin
                slot_block_reg[i] <= slot_block_next[i];
            end
        end
    end

endmodule

`default_nettype wire

[design/banked_rom_ram_mapper_top.sv]
// Banked ROM/RAM mapper: clearing pass, memory access stage and output register.
// Each result passes the memory stage register, then the output register once that is free.
// Throughput: one item per cycle unless the output stalls; at most one RAM or ROM port access per item.
// Reset: slot blocks and lock cleared at once; a clearing pass then zeroes the RAM,
// one byte a cycle over all RAM_BYTES bytes (32768 by default), with no item taken meanwhile.
// ROM contents are undefined until loaded.
`default_nettype none

module banked_rom_ram_mapper_top
    import bmm_pkg::*;
#(
    parameter int ROM_BYTES = ROM_BYTES_C,
    parameter int RAM_BYTES = RAM_BYTES_C
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode[1:0], address[17:2], data[25:18], load_offset[42:26], zero[47:43]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[7:0]
    output logic      [7:0]  m_tdata
);

    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int ROM_AW = $clog2(ROM_BYTES);

    bmm_req_t          req;
    logic              accept;
    logic [RAM_AW-1:0] dec_ram_addr;
    logic [7:0]        dec_ram_wdata;
    logic [ROM_AW-1:0] dec_rom_addr;

    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [RAM_AW-1:0] clr_addr_reg;
    logic [RAM_AW-1:0] clr_addr_next;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_q;
    logic [7:0]        rom_q;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    src_t              s1_src_reg;
    logic              out_load;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_data_reg;
    logic [7:0]        out_data_next;

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || out_load);
    assign accept   = s_tvalid && s_tready;

    bmm_decode #(
        .ROM_BYTES (ROM_BYTES),
        .RAM_BYTES (RAM_BYTES)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (s_tdata[1:0]),
        .address     (s_tdata[17:2]),
        .data        (s_tdata[25:18]),
        .load_offset (s_tdata[42:26]),
        .req         (req),
        .ram_addr    (dec_ram_addr),
        .ram_wdata   (dec_ram_wdata),
        .rom_addr    (dec_rom_addr)
    );

    assign ram_we    = clr_busy_reg || (accept && req.ram_we);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : dec_ram_addr;
    assign ram_wdata = clr_busy_reg ? 8'h00 : dec_ram_wdata;

    bmm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept && req.ram_re),
        .raddr (dec_ram_addr),
        .rdata (ram_q)
    );

    bmm_ram #(
        .WIDTH (8),
        .DEPTH (ROM_BYTES)
    ) u_rom (
        .clk   (clk),
        .we    (accept && req.rom_we),
        .waddr (dec_rom_addr),
        .wdata (s_tdata[25:18]),
        .re    (accept && req.rom_re),
        .raddr (dec_rom_addr),
        .rdata (rom_q)
    );

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + RAM_AW'(1);
            if (clr_addr_reg == {RAM_AW{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (s1_src_reg)
            SRC_RAM:  out_data_next = ram_q;
            SRC_ROM:  out_data_next = rom_q;
            default:  out_data_next = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg <= req.src;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_tready)
        else $error("item taken during RAM clearing pass");

    a_single_port_access: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> $onehot0({req.ram_we, req.ram_re, req.rom_we, req.rom_re}))
        else $error("item decoded to more than one memory access");

    a_stage_filled: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before the memory stage");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (s1_src_reg == SRC_ZERO)) |=> (m_tvalid && (m_tdata == 8'h00)))
        else $error("non-read result is not zero");
`endif

endmodule

`default_nettype wire

[dv/tb_banked_rom_ram_mapper_top.sv]
// Self-checking stream testbench for the banked ROM/RAM cartridge mapper.
`default_nettype none

module tb_banked_rom_ram_mapper_top;
    import bmm_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 625;
    localparam int         CALM_ITEMS   = 100;
    localparam int         QUIET_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [6:0] ROM_POOL [4] = '{7'h00, 7'h01, 7'h02, 7'h7F};

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  data;
        logic [16:0] load_offset;
        bit          known;
        logic [7:0]  read_data;
    } access_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // mode[1:0], address[17:2], data[25:18], load_offset[42:26], zero[47:43]
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // read_data[7:0]
    logic [7:0]  m_tdata;

    logic [7:0]  slot_blk [4];
    bit          slot3_locked;
    logic [7:0]  ram_img [RAM_BYTES_C];
    logic [7:0]  rom_img [ROM_BYTES_C];
    bit          rom_known [ROM_BYTES_C];

    logic [7:0]  expected_read_q [$];
    access_t     directed_plan [26];
    bit          calm;
    int          errors;
    int          quiet_cycles;

    banked_rom_ram_mapper_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit lock_after(logic [12:0] a);
        if (a == LOCK_ADDR_A || a == LOCK_ADDR_B)
            return 1'b1;
        if (slot3_locked && a >= UNLOCK_LO && a <= UNLOCK_HI)
            return 1'b0;
        return slot3_locked;
    endfunction

    function automatic logic [7:0] block_at(logic [12:0] a, bit lk);
        if (lk && a[11:10] == SLOT_LAST)
            return LOCKED_BLOCK;
        return slot_blk[a[11:10]];
    endfunction

    function automatic logic [7:0] mapper_predict(access_t acc);
        logic [12:0] a;
        logic [7:0]  blk;
        logic [7:0]  r;
        a = acc.address[12:0];
        r = 8'h00;
        case (acc.mode)
            MODE_READ:
            begin
                slot3_locked = lock_after(a);
                if (a >= UNLOCK_LO)
                begin
                    blk = block_at(a, slot3_locked);
                    if (blk[7])
                        r = rom_img[{blk[6:0], a[9:0]}];
                    else if (a[9])
                        r = ram_img[{blk[5:0], a[8:0]}];
                    else
                        ram_img[{blk[5:0], a[8:0]}] = 8'h00;
                end
            end
            MODE_WRITE:
            begin
                slot3_locked = lock_after(a);
                if (a >= BANK_REG_LO && a <= BANK_REG_HI)
                    slot_blk[a[1:0]] = acc.data;
                else if (a >= UNLOCK_LO)
                begin
                    blk = block_at(a, slot3_locked);
                    if (!blk[7] && !a[9])
                        ram_img[{blk[5:0], a[8:0]}] = acc.data;
                end
            end
            MODE_LOAD:
            begin
                rom_img[acc.load_offset] = acc.data;
                rom_known[acc.load_offset] = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [9:0] near_offset();
        if ($urandom_range(0, 3) == 0)
            return 10'($urandom);
        return {1'($urandom), 5'b0, 4'($urandom)};
    endfunction

    task automatic pick_access(output access_t acc);
        int          pick;
        logic [12:0] a;
        logic [7:0]  blk;
        logic [6:0]  page;
        pick = $urandom_range(0, 99);
        acc.known = 1'b0;
        acc.read_data = 8'h00;
        acc.data = 8'($urandom);
        acc.load_offset = 17'($urandom);
        acc.address = 16'($urandom);
        page = ($urandom_range(0, 3) == 0) ? 7'($urandom) : ROM_POOL[$urandom_range(0, 3)];
        if (pick < 12)
        begin
            acc.mode = MODE_LOAD;
            acc.load_offset = {page, near_offset()};
        end
        else if (pick < 22)
        begin
            acc.mode = MODE_WRITE;
            a = BANK_REG_LO + 13'($urandom_range(0, 3));
            acc.address[12:0] = a;
            if ($urandom_range(0, 1) == 0)
                acc.data = {1'b1, page};
            else if ($urandom_range(0, 3) != 0)
                acc.data = {1'b0, 7'($urandom)};
        end
        else if (pick < 27)
        begin
            acc.mode = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
            acc.address[12:0] = ($urandom_range(0, 1) == 0) ? LOCK_ADDR_A : LOCK_ADDR_B;
        end
        else if (pick < 32)
        begin
            acc.mode = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
            acc.address[12] = 1'b0;
        end
        else if (pick < 34)
        begin
            acc.mode = MODE_UNUSED;
        end
        else
        begin
            acc.mode = ($urandom_range(0, 99) < 55) ? MODE_READ : MODE_WRITE;
            acc.address[12:0] = {1'b1, 2'($urandom), near_offset()};
        end
        // turn a read of an unloaded ROM byte into a load of that byte
        a = acc.address[12:0];
        if (acc.mode == MODE_READ && a >= UNLOCK_LO)
        begin
            blk = block_at(a, lock_after(a));
            if (blk[7] && !rom_known[{blk[6:0], a[9:0]}])
            begin
                acc.mode = MODE_LOAD;
                acc.load_offset = {blk[6:0], a[9:0]};
            end
        end
    endtask

    task automatic drive_access(access_t acc);
        logic [7:0] want;
        want = mapper_predict(acc);
        if (acc.known)
            want = acc.read_data;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, acc.load_offset, acc.data, acc.address, acc.mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_read_q.push_back(want);
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_read_q.size() == 0)
                report_mismatch($sformatf("read_data %02h with no item pending", m_tdata));
            else if (m_tdata !== expected_read_q[0])
            begin
                report_mismatch($sformatf("read_data %02h, want %02h",
                                          m_tdata, expected_read_q[0]));
                void'(expected_read_q.pop_front());
            end
            else
                void'(expected_read_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    initial
    begin
        access_t acc;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        slot3_locked = 1'b0;
        foreach (slot_blk[i])
            slot_blk[i] = 8'h00;
        foreach (ram_img[i])
            ram_img[i] = 8'h00;
        foreach (rom_img[i])
        begin
            rom_img[i] = 8'h00;
            rom_known[i] = 1'b0;
        end

        directed_plan = '{
            '{MODE_READ,   16'h1000, 8'h00, 17'h00000, 1'b1, 8'h00},
            '{MODE_READ,   16'h1200, 8'h00, 17'h00000, 1'b1, 8'h00},
            '{MODE_READ,   16'h0000, 8'h00, 17'h00000, 1'b1, 8'h00},
            '{MODE_WRITE,  16'h1005, 8'hA5, 17'h00000, 1'b1, 8'h00},
            '{MODE_READ,   16'h1205, 8'h00, 17'h00000, 1'b0, 8'h00},
            '{MODE_READ,   16'h1005, 8'h00, 17'h00000, 1'b1, 8'h00},
            '{MODE_READ,   16'h1205, 8'h00, 17'h00000, 1'b0, 8'h00},
            '{MODE_WRITE,  16'h1205, 8'h5A, 17'h00000, 1'b1, 8'h00},
            '{MODE_LOAD,   16'h0000, 8'hFF, 17'h1FFFF, 1'b1, 8'h00},
            '{MODE_LOAD,   16'h0000, 8'h3C, 17'h00000, 1'b1, 8'h00},
            '{MODE_LOAD,   16'h0000, 8'hC3, 17'h1FFFC, 1'b1, 8'h00},
            '{MODE_LOAD,   16'h0000, 8'h7E, 17'h1FFFD, 1'b1, 8'h00},
            '{MODE_WRITE,  16'h003C, 8'h80, 17'h00000, 1'b1, 8'h00},
            '{MODE_READ,   16'h1000, 8'h00, 17'h00000, 1'b0, 8'h00},
            '{MODE_WRITE,  16'h1000, 8'h11, 17'h00000, 1'b1, 8'h00},
            '{MODE_READ,   16'h1FFC, 8'h00, 17'h00000, 1'b0, 8'h00},
            '{MODE_READ,   16'hFFFF, 8'h00, 17'h00000, 1'b0, 8'h00},
            '{MODE_READ,   16'h1800, 8'h00, 17'h00000, 1'b1, 8'h00},
            '{MODE_WRITE,  16'h003F, 8'h3F, 17'h00000, 1'b1, 8'h00},
            '{MODE_WRITE,  16'h1DFF, 8'hFF, 17'h00000, 1'b1, 8'h00},
            '{MODE_READ,   16'h1FFF, 8'h00, 17'h00000, 1'b0, 8'h00},
            '{MODE_WRITE,  16'hFFFD, 8'h12, 17'h00000, 1'b1, 8'h00},
            '{MODE_UNUSED, 16'h1000, 8'hFF, 17'h1FFFF, 1'b1, 8'h00},
            '{MODE_WRITE,  16'h1400, 8'h01, 17'h00000, 1'b1, 8'h00},
            '{MODE_READ,   16'h1E00, 8'h00, 17'h00000, 1'b0, 8'h00},
            '{MODE_READ,   16'h1600, 8'h00, 17'h00000, 1'b0, 8'h00}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
            drive_access(directed_plan[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
            pick_access(acc);
            drive_access(acc);
        end
        s_tvalid <= 1'b0;

        while (expected_read_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
